// File: design/rtc_calendar_alarm_defines.svh
// Assertion macros shared by the clock and calendar RTL.
// Each macro takes a label, the clock, the active-low reset, the checked
// expressions and a message string.
`ifndef RTC_CALENDAR_ALARM_DEFINES_SVH
`define RTC_CALENDAR_ALARM_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define RCA_ASSERT_ALWAYS(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define RCA_ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define RCA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rtccal_pkg.sv
`default_nettype none

package rtccal_pkg;

    // Request codes carried by req_type.
    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_LOAD_TIME = 2'd1,
        REQ_LOAD_DATE = 2'd2
    } req_type_t;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_HOURS      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_MINUTES    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_SECONDS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_ENABLE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TWELVE_HOUR_MODE = 3'd4;

    // Counter limits.
    localparam logic [5:0] MAX_SECOND = 6'd59;
    localparam logic [5:0] MAX_MINUTE = 6'd59;
    localparam logic [4:0] MAX_HOUR   = 5'd23;
    localparam logic [4:0] HALF_DAY   = 5'd12;
    localparam logic [3:0] MONTHS     = 4'd12;

    // Reset values.
    localparam logic [5:0] RST_SECONDS     = 6'd30;
    localparam logic [5:0] RST_MINUTES     = 6'd9;
    localparam logic [4:0] RST_HOURS       = 5'd19;
    localparam logic [4:0] RST_DAY         = 5'd31;
    localparam logic [3:0] RST_MONTH       = 4'd12;
    localparam logic [4:0] RST_ALARM_HOURS = 5'd8;

    typedef struct packed {
        logic [4:0] alarm_hours;
        logic [5:0] alarm_minutes;
        logic [5:0] alarm_seconds;
        logic       alarm_enable;
        logic       twelve_hour_mode;
    } cfg_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] day;
        logic [3:0] month;
    } clock_state_t;

    typedef struct packed {
        logic [4:0] display_hours;
        logic       is_pm;
        logic       alarm_hit;
        logic       half_day_turned;
        logic       day_turned;
    } result_t;

    // Days in a month, February fixed at 28.
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] len;
        begin
            case (month)
                4'd2:    len = 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/rtccal_cfg.sv
`default_nettype none

module rtccal_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [rtccal_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [rtccal_pkg::CFG_DATA_W-1:0]  wr_data,
    output rtccal_pkg::cfg_t                        cfg
);
    import rtccal_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes to indexes beyond the register list leave everything unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_ALARM_HOURS:      cfg_next.alarm_hours      = wr_data[4:0];
                CFG_ALARM_MINUTES:    cfg_next.alarm_minutes    = wr_data[5:0];
                CFG_ALARM_SECONDS:    cfg_next.alarm_seconds    = wr_data[5:0];
                CFG_ALARM_ENABLE:     cfg_next.alarm_enable     = wr_data[0];
                CFG_TWELVE_HOUR_MODE: cfg_next.twelve_hour_mode = wr_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_hours      <= RST_ALARM_HOURS;
            cfg_reg.alarm_minutes    <= 6'd0;
            cfg_reg.alarm_seconds    <= 6'd0;
            cfg_reg.alarm_enable     <= 1'b0;
            cfg_reg.twelve_hour_mode <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/rtccal_step.sv
`default_nettype none

module rtccal_step (
    input  wire rtccal_pkg::cfg_t         cfg,
    input  wire rtccal_pkg::clock_state_t cur,
    input  wire logic [1:0]               req_type,
    input  wire logic [4:0]               new_hours,
    input  wire logic [5:0]               new_minutes,
    input  wire logic [5:0]               new_seconds,
    input  wire logic [4:0]               new_day,
    input  wire logic [3:0]               new_month,
    output rtccal_pkg::clock_state_t      nxt,
    output rtccal_pkg::result_t           res
);
    import rtccal_pkg::*;

    logic       sec_wrap;
    logic       min_wrap;
    logic       hour_wrap;
    logic       month_end;
    logic       midnight;
    clock_state_t tick_state;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [4:0] load_len;
    logic       alarm_match;

    // Cascaded counters for the one-second tick.
    always_comb
    begin
        sec_wrap  = cur.seconds >= MAX_SECOND;
        min_wrap  = sec_wrap && (cur.minutes >= MAX_MINUTE);
        hour_wrap = min_wrap && (cur.hours >= MAX_HOUR);
        month_end = cur.day >= month_days(cur.month);
        midnight  = hour_wrap;

        tick_state = cur;
        tick_state.seconds = sec_wrap ? 6'd0 : cur.seconds + 6'd1;
        if (sec_wrap)
        begin
            tick_state.minutes = min_wrap ? 6'd0 : cur.minutes + 6'd1;
        end
        if (min_wrap)
        begin
            tick_state.hours = hour_wrap ? 5'd0 : cur.hours + 5'd1;
        end
        if (midnight)
        begin
            tick_state.day = month_end ? 5'd1 : cur.day + 5'd1;
            if (month_end)
            begin
                tick_state.month = (cur.month >= MONTHS) ? 4'd1 : cur.month + 4'd1;
            end
        end
    end

    // Date load with the month forced into 1..12 and the day into the month.
    always_comb
    begin
        load_month = (new_month > MONTHS) ? MONTHS : new_month;
        if (load_month == 4'd0)
        begin
            load_month = 4'd1;
        end
        load_len = month_days(load_month);
        load_day = (new_day == 5'd0) ? 5'd1 : new_day;
        if (load_day > load_len)
        begin
            load_day = load_len;
        end
    end

    assign alarm_match = cfg.alarm_enable
                      && (cfg.alarm_hours == cur.hours)
                      && (cfg.alarm_minutes == cur.minutes)
                      && (cfg.alarm_seconds == cur.seconds);

    always_comb
    begin
        nxt = cur;
        res.alarm_hit       = 1'b0;
        res.half_day_turned = 1'b0;
        res.day_turned      = 1'b0;
        case (req_type)
            REQ_TICK:
            begin
                nxt = tick_state;
                res.alarm_hit       = alarm_match;
                res.half_day_turned = hour_wrap || (min_wrap && (cur.hours == HALF_DAY - 5'd1));
                res.day_turned      = midnight;
            end
            REQ_LOAD_TIME:
            begin
                nxt.hours   = (new_hours > MAX_HOUR) ? MAX_HOUR : new_hours;
                nxt.minutes = (new_minutes > MAX_MINUTE) ? MAX_MINUTE : new_minutes;
                nxt.seconds = (new_seconds > MAX_SECOND) ? MAX_SECOND : new_seconds;
            end
            REQ_LOAD_DATE:
            begin
                nxt.month = load_month;
                nxt.day   = load_day;
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        res.is_pm = nxt.hours >= HALF_DAY;
        res.display_hours = (cfg.twelve_hour_mode && res.is_pm) ? nxt.hours - HALF_DAY
                                                                : nxt.hours;
    end

endmodule

`default_nettype wire

// File: design/rtc_calendar_alarm.sv
// Real-time clock and calendar with an alarm comparator.
// Requests enter on the input channel (in_valid / in_stall) and carry a
// request type: a one-second tick, a time load or a date load. Every request
// produces exactly one result on the output channel (out_valid / out_stall)
// holding the time and date after the request, the display hour, the PM bit
// and the alarm, half-day and new-day flags.
// A request is held in an input register; when the result slot is free or
// being taken, the next state and the flags are computed from it and
// written into the state and result registers together.
// One request is accepted every cycle as long as results are taken; the
// state feedback is a single pass through the counter cascade, so each
// request sees the state that the previous one left.
// When the receiver stalls, the result registers hold and the input register
// fills; in_stall then rises until the result is taken.
// The alarm and display registers must be written through the configuration
// port only while no request is in flight; the block does not enforce this.
// Reset sets the time to 19:09:30 on December 31, the alarm to 08:00:00
// disarmed, and twelve-hour display on; both channels come up empty.
`default_nettype none

module rtc_calendar_alarm (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [rtccal_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [rtccal_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [1:0]                         req_type,
    input  wire logic [4:0]                         new_hours,
    input  wire logic [5:0]                         new_minutes,
    input  wire logic [5:0]                         new_seconds,
    input  wire logic [4:0]                         new_day,
    input  wire logic [3:0]                         new_month,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [4:0]                              hours_now,
    output logic [5:0]                              minutes_now,
    output logic [5:0]                              seconds_now,
    output logic [4:0]                              day_now,
    output logic [3:0]                              month_now,
    output logic [4:0]                              display_hours,
    output logic                                    is_pm,
    output logic                                    alarm_hit,
    output logic                                    half_day_turned,
    output logic                                    day_turned
);
    import rtccal_pkg::*;

`include "rtc_calendar_alarm_defines.svh"

    cfg_t         cfg;
    clock_state_t state_reg;
    clock_state_t state_next;
    result_t      flags_reg;
    result_t      flags_next;

    // Input register.
    logic         req_valid_reg;
    logic         req_valid_next;
    logic [1:0]   req_type_reg;
    logic [4:0]   new_hours_reg;
    logic [5:0]   new_minutes_reg;
    logic [5:0]   new_seconds_reg;
    logic [4:0]   new_day_reg;
    logic [3:0]   new_month_reg;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic         advance;
    logic         in_take;

    // Conditions checked by the assertions below.
    logic         state_in_range;
    logic         at_midnight;
    logic         on_half_day;

    rtccal_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_wr_index),
        .wr_data  (cfg_wr_data),
        .cfg      (cfg)
    );

    rtccal_step u_step (
        .cfg         (cfg),
        .cur         (state_reg),
        .req_type    (req_type_reg),
        .new_hours   (new_hours_reg),
        .new_minutes (new_minutes_reg),
        .new_seconds (new_seconds_reg),
        .new_day     (new_day_reg),
        .new_month   (new_month_reg),
        .nxt         (state_next),
        .res         (flags_next)
    );

    // The held request moves on when the result slot is empty or being taken.
    assign advance  = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_take)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_type_reg    <= req_type;
            new_hours_reg   <= new_hours;
            new_minutes_reg <= new_minutes;
            new_seconds_reg <= new_seconds;
            new_day_reg     <= new_day;
            new_month_reg   <= new_month;
        end
    end

    // The clock state only changes when a result is loaded, so while a result
    // waits the state register also serves as its time and date fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.hours   <= RST_HOURS;
            state_reg.minutes <= RST_MINUTES;
            state_reg.seconds <= RST_SECONDS;
            state_reg.day     <= RST_DAY;
            state_reg.month   <= RST_MONTH;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flags_reg <= flags_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hours_now       = state_reg.hours;
    assign minutes_now     = state_reg.minutes;
    assign seconds_now     = state_reg.seconds;
    assign day_now         = state_reg.day;
    assign month_now       = state_reg.month;
    assign display_hours   = flags_reg.display_hours;
    assign is_pm           = flags_reg.is_pm;
    assign alarm_hit       = flags_reg.alarm_hit;
    assign half_day_turned = flags_reg.half_day_turned;
    assign day_turned      = flags_reg.day_turned;

    assign state_in_range = (state_reg.hours <= MAX_HOUR)
                         && (state_reg.minutes <= MAX_MINUTE)
                         && (state_reg.seconds <= MAX_SECOND)
                         && (state_reg.day != 5'd0)
                         && (state_reg.month != 4'd0)
                         && (state_reg.month <= MONTHS);

    assign at_midnight = (state_reg.hours == 5'd0)
                      && (state_reg.minutes == 6'd0)
                      && (state_reg.seconds == 6'd0)
                      && (state_reg.day != 5'd0);

    assign on_half_day = (state_reg.hours == HALF_DAY || state_reg.hours == 5'd0)
                      && (state_reg.minutes == 6'd0)
                      && (state_reg.seconds == 6'd0);

    // Loads saturate, so the counters never leave their ranges.
    `RCA_ASSERT_ALWAYS(a_state_in_range, clk, rst_n, state_in_range, "clock state out of range")

    // A new day always lands exactly on midnight and is also a half-day turn.
    `RCA_ASSERT_IMPLIES(a_day_turn_midnight, clk, rst_n, out_valid_reg && flags_reg.day_turned, flags_reg.half_day_turned && at_midnight, "day turned away from midnight")

    // A half-day turn leaves the clock at noon or midnight.
    `RCA_ASSERT_IMPLIES(a_half_day_turn, clk, rst_n, out_valid_reg && flags_reg.half_day_turned, on_half_day, "half-day flag off the hour")

    // The PM bit follows the hour of the waiting result.
    `RCA_ASSERT_IMPLIES(a_pm_matches_hour, clk, rst_n, out_valid_reg, flags_reg.is_pm == (state_reg.hours >= HALF_DAY), "PM bit disagrees with hour")

    // A request that cannot move on stays in the input register.
    `RCA_ASSERT_NEXT(a_req_held, clk, rst_n, req_valid_reg && !advance, req_valid_reg && out_valid_reg, "held request lost")

endmodule

`default_nettype wire

// File: tb/rtc_calendar_alarm_test.sv
// Self-checking testbench for the real-time clock and calendar block.
module rtc_calendar_alarm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtccal_pkg::*;

    // The request code that the block must treat as a no-op.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Register indexes with no register behind them; writes there are dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 3'd7;

    localparam int  DRAIN_CYCLES = 6;
    localparam int  HOLD_CYCLES  = 48;
    localparam int  MAX_REPORTS  = 40;
    localparam real TIMEOUT_NS   = 2000000.0;

    // One request as it is offered on the input channel.
    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] day;
        logic [3:0] month;
    } request_t;

    // One clock reading as it leaves on the output channel.
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] day;
        logic [3:0] month;
        logic [4:0] disp_hours;
        logic       pm;
        logic       hit;
        logic       half_turn;
        logic       day_turn;
    } reading_t;

    // Every input of the block starts at a known value.
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;
    logic                   in_valid     = 1'b0;
    logic [1:0]             req_type     = '0;
    logic [4:0]             new_hours    = '0;
    logic [5:0]             new_minutes  = '0;
    logic [5:0]             new_seconds  = '0;
    logic [4:0]             new_day      = 5'd1;
    logic [3:0]             new_month    = 4'd1;
    logic                   out_stall    = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic [4:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic [4:0] day_now;
    logic [3:0] month_now;
    logic [4:0] display_hours;
    logic       is_pm;
    logic       alarm_hit;
    logic       half_day_turned;
    logic       day_turned;

    rtc_calendar_alarm uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .new_hours       (new_hours),
        .new_minutes     (new_minutes),
        .new_seconds     (new_seconds),
        .new_day         (new_day),
        .new_month       (new_month),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hours_now       (hours_now),
        .minutes_now     (minutes_now),
        .seconds_now     (seconds_now),
        .day_now         (day_now),
        .month_now       (month_now),
        .display_hours   (display_hours),
        .is_pm           (is_pm),
        .alarm_hit       (alarm_hit),
        .half_day_turned (half_day_turned),
        .day_turned      (day_turned)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The testbench keeps its own copy of the clock and calendar, starting
    // from the reset time 19:09:30 on December 31.
    logic [4:0] now_hours   = 5'd19;
    logic [5:0] now_minutes = 6'd9;
    logic [5:0] now_seconds = 6'd30;
    logic [4:0] now_day     = 5'd31;
    logic [3:0] now_month   = 4'd12;

    // Its copy of the configuration registers, at their reset values.
    logic [4:0] alarm_at_hours   = 5'd8;
    logic [5:0] alarm_at_minutes = 6'd0;
    logic [5:0] alarm_at_seconds = 6'd0;
    logic       alarm_armed      = 1'b0;
    logic       twelve_hour      = 1'b1;

    request_t pending_requests[$];
    reading_t expected_readings[$];

    int requests_queued = 0;
    int requests_taken  = 0;
    int results_seen    = 0;
    int failures        = 0;
    int field_errors    = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int hold_left    = 0;
    int holds_done   = 0;
    int next_hold_at = 150;

    // Month lengths with a 28-day February; leap years are not modeled.
    function automatic logic [4:0] days_of(input logic [3:0] month);
        case (month)
            4'd2:                      return 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
            default:                   return 5'd31;
        endcase
    endfunction

    // Applies one accepted request to the local clock and returns the reading
    // that the block has to produce for it.
    function automatic reading_t apply_request(input request_t r);
        reading_t   o;
        logic [3:0] mo;
        logic [4:0] d;
        o = '0;
        case (r.kind)
            REQ_TICK:
            begin
                // The alarm looks at the time before this second is counted.
                o.hit = alarm_armed && alarm_at_hours == now_hours
                        && alarm_at_minutes == now_minutes
                        && alarm_at_seconds == now_seconds;
                if (now_seconds != MAX_SECOND)
                    now_seconds = now_seconds + 6'd1;
                else
                begin
                    now_seconds = '0;
                    if (now_minutes != MAX_MINUTE)
                        now_minutes = now_minutes + 6'd1;
                    else
                    begin
                        now_minutes = '0;
                        if (now_hours != MAX_HOUR)
                        begin
                            now_hours   = now_hours + 5'd1;
                            o.half_turn = (now_hours == HALF_DAY);
                        end
                        else
                        begin
                            // Midnight: new day, possibly new month and year.
                            now_hours   = '0;
                            o.half_turn = 1'b1;
                            o.day_turn  = 1'b1;
                            if (now_day < days_of(now_month))
                                now_day = now_day + 5'd1;
                            else
                            begin
                                now_day   = 5'd1;
                                now_month = (now_month == MONTHS) ? 4'd1 : now_month + 4'd1;
                            end
                        end
                    end
                end
            end
            REQ_LOAD_TIME:
            begin
                now_hours   = (r.hours > MAX_HOUR) ? MAX_HOUR : r.hours;
                now_minutes = (r.minutes > MAX_MINUTE) ? MAX_MINUTE : r.minutes;
                now_seconds = (r.seconds > MAX_SECOND) ? MAX_SECOND : r.seconds;
            end
            REQ_LOAD_DATE:
            begin
                mo = (r.month > MONTHS) ? MONTHS : r.month;
                if (mo == 4'd0)
                    mo = 4'd1;
                d = (r.day == 5'd0) ? 5'd1 : r.day;
                if (d > days_of(mo))
                    d = days_of(mo);
                now_month = mo;
                now_day   = d;
            end
            default:
            begin
            end
        endcase
        o.hours      = now_hours;
        o.minutes    = now_minutes;
        o.seconds    = now_seconds;
        o.day        = now_day;
        o.month      = now_month;
        o.pm         = (now_hours >= HALF_DAY);
        o.disp_hours = (twelve_hour && o.pm) ? now_hours - HALF_DAY : now_hours;
        return o;
    endfunction

    task automatic push_request(input logic [1:0] kind, input logic [4:0] h,
                                input logic [5:0] m, input logic [5:0] s,
                                input logic [4:0] d, input logic [3:0] mo);
        request_t r;
        r.kind    = kind;
        r.hours   = h;
        r.minutes = m;
        r.seconds = s;
        r.day     = d;
        r.month   = mo;
        pending_requests.push_back(r);
        requests_queued++;
    endtask

    // Fields that a request does not use carry random values.
    task automatic push_tick();
        push_request(REQ_TICK, 5'($urandom_range(31)), 6'($urandom_range(63)),
                     6'($urandom_range(63)), 5'($urandom_range(31)), 4'($urandom_range(15)));
    endtask

    task automatic push_time(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
        push_request(REQ_LOAD_TIME, h, m, s, 5'($urandom_range(31)), 4'($urandom_range(15)));
    endtask

    task automatic push_date(input logic [4:0] d, input logic [3:0] mo);
        push_request(REQ_LOAD_DATE, 5'($urandom_range(31)), 6'($urandom_range(63)),
                     6'($urandom_range(63)), d, mo);
    endtask

    // Random traffic. Most of it loads a time, usually just short of an
    // interesting boundary (the alarm, noon, midnight, the top of an hour),
    // sometimes a month-end date too, and then ticks across it. The rest is plain tick
    // runs and requests with every field fully random, unused code included.
    task automatic queue_random(input int count);
        int         stop_at;
        int         mode;
        int         k;
        int         steps;
        logic [4:0] h;
        logic [5:0] m;
        logic [5:0] s;
        stop_at = requests_queued + count;
        while (requests_queued < stop_at)
        begin
            mode = $urandom_range(99);
            if (mode < 60)
            begin
                k = $urandom_range(6);
                case ($urandom_range(4))
                    0:
                    begin
                        h = (alarm_at_hours > MAX_HOUR) ? MAX_HOUR : alarm_at_hours;
                        m = (alarm_at_minutes > MAX_MINUTE) ? MAX_MINUTE : alarm_at_minutes;
                        s = (alarm_at_seconds > MAX_SECOND) ? MAX_SECOND : alarm_at_seconds;
                        s = (s >= 6'(k)) ? s - 6'(k) : 6'd0;
                    end
                    1:
                    begin
                        h = 5'd11;
                        m = MAX_MINUTE;
                        s = MAX_SECOND - 6'(k);
                    end
                    2:
                    begin
                        h = MAX_HOUR;
                        m = MAX_MINUTE;
                        s = MAX_SECOND - 6'(k);
                    end
                    3:
                    begin
                        h = 5'($urandom_range(23));
                        m = MAX_MINUTE;
                        s = MAX_SECOND - 6'(k);
                    end
                    default:
                    begin
                        h = 5'($urandom_range(23));
                        m = 6'($urandom_range(59));
                        s = 6'($urandom_range(59));
                    end
                endcase
                push_time(h, m, s);
                if ($urandom_range(1) == 1)
                    push_date(($urandom_range(2) == 0) ? 5'($urandom_range(1, 31)) : 5'd31,
                              4'($urandom_range(1, 12)));
                steps = $urandom_range(k + 1, k + 4);
                repeat (steps)
                    push_tick();
            end
            else if (mode < 85)
            begin
                steps = $urandom_range(1, 20);
                repeat (steps)
                    push_tick();
            end
            else
                push_request(2'($urandom_range(3)), 5'($urandom_range(31)),
                             6'($urandom_range(63)), 6'($urandom_range(63)),
                             5'($urandom_range(31)), 4'($urandom_range(15)));
        end
    endtask

    // Directed opening, run with the reset configuration: alarm disarmed,
    // twelve-hour display on.
    task automatic queue_directed();
        push_tick();
        push_request(REQ_UNUSED, 5'h1F, 6'h3F, 6'h3F, 5'h1F, 4'hF);
        push_time(5'd23, 6'd59, 6'd59);
        push_tick();                    // midnight on New Year's Eve
        push_time(5'd11, 6'd59, 6'd59);
        push_tick();                    // noon, shown as hour 0
        push_time(5'h1F, 6'h3F, 6'h3F); // saturates to 23:59:59
        push_time(5'd0, 6'd0, 6'd0);
        push_date(5'd0, 4'd0);          // zero day and month move up to 1
        push_date(5'd31, 4'd15);        // month above 12 clamps to December
        push_date(5'd31, 4'd2);         // day clamps to February's 28
        push_time(5'd23, 6'd59, 6'd59);
        push_tick();                    // February 28 rolls to March 1
        push_date(5'd31, 4'd4);
        push_date(5'd30, 4'd12);
        push_time(5'd23, 6'd59, 6'd58);
        push_tick();
        push_tick();                    // December 30 rolls to December 31
        push_time(5'd8, 6'd0, 6'd0);
        push_tick();                    // matches the alarm time, but disarmed
        push_time(5'd12, 6'd0, 6'd0);
        push_time(5'd13, 6'd30, 6'd45);
        push_time(5'd10, 6'd59, 6'd59);
        push_tick();                    // top of the hour without a half-day turn
        push_date(5'd1, 4'd1);
    endtask

    // Register writes only happen while no request is in flight, so the
    // local copy is updated at the moment the write is issued.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        case (index)
            CFG_ALARM_HOURS:      alarm_at_hours   = value[4:0];
            CFG_ALARM_MINUTES:    alarm_at_minutes = value;
            CFG_ALARM_SECONDS:    alarm_at_seconds = value;
            CFG_ALARM_ENABLE:     alarm_armed      = value[0];
            CFG_TWELVE_HOUR_MODE: twelve_hour      = value[0];
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every queued request has produced its result, then gives
    // the two-stage pipeline time to settle.
    task automatic wait_until_drained();
        while (results_seen != requests_queued)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            field_errors++;
            if (failures < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Request driver. A request is taken at an edge where in_valid is high
    // and in_stall is low; its reading is predicted right then, so the
    // predictions are stored in acceptance order. A stalled request is held
    // unchanged; otherwise whether the next one is offered depends only on
    // the queue of pending requests and the random idle rate.
    always @(posedge clk)
    begin
        request_t next_req;
        request_t taken;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                taken = {req_type, new_hours, new_minutes, new_seconds, new_day, new_month};
                expected_readings.push_back(apply_request(taken));
                requests_taken <= requests_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_requests.pop_front();
                    in_valid    <= 1'b1;
                    req_type    <= next_req.kind;
                    new_hours   <= next_req.hours;
                    new_minutes <= next_req.minutes;
                    new_seconds <= next_req.seconds;
                    new_day     <= next_req.day;
                    new_month   <= next_req.month;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off. Twice during the run the result side stops
    // taking results for a long stretch while requests keep coming, so the
    // block fills up and has to raise in_stall.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && requests_taken >= next_hold_at)
        begin
            hold_left    <= HOLD_CYCLES;
            holds_done   <= holds_done + 1;
            next_hold_at <= next_hold_at + 1200;
        end
    end

    // Result monitor. Each result taken is checked field by field against
    // the oldest prediction; a result with nothing predicted is an error.
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_readings.size() == 0)
                begin
                    if (failures < MAX_REPORTS)
                        $display("%0t: result with no request outstanding, hours %0d",
                                 $time, hours_now);
                    failures++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    field_errors = 0;
                    compare_field("hours_now", 32'(want.hours), 32'(hours_now));
                    compare_field("minutes_now", 32'(want.minutes), 32'(minutes_now));
                    compare_field("seconds_now", 32'(want.seconds), 32'(seconds_now));
                    compare_field("day_now", 32'(want.day), 32'(day_now));
                    compare_field("month_now", 32'(want.month), 32'(month_now));
                    compare_field("display_hours", 32'(want.disp_hours),
                                  32'(display_hours));
                    compare_field("is_pm", 32'(want.pm), 32'(is_pm));
                    compare_field("alarm_hit", 32'(want.hit), 32'(alarm_hit));
                    compare_field("half_day_turned", 32'(want.half_turn),
                                  32'(half_day_turned));
                    compare_field("day_turned", 32'(want.day_turn), 32'(day_turned));
                    if (field_errors != 0)
                        failures++;
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Stimulus phases. Each configuration is set while the block is idle.
    initial
    begin
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 29;
        recv_idle_pct <= 51;

        // Reset configuration first, so its values are exercised unchanged.
        queue_directed();
        wait_until_drained();

        // Alarm at the last second of the day, armed, 24-hour display.
        // The opening requests hit the alarm on the tick that also turns
        // the year.
        write_register(CFG_ALARM_HOURS, 6'd23);
        write_register(CFG_ALARM_MINUTES, 6'd59);
        write_register(CFG_ALARM_SECONDS, 6'd59);
        write_register(CFG_ALARM_ENABLE, 6'd1);
        write_register(CFG_TWELVE_HOUR_MODE, 6'd0);
        push_date(5'd31, 4'd12);
        push_time(5'd23, 6'd59, 6'd58);
        push_tick();
        push_tick();
        queue_random(550);
        wait_until_drained();

        // Alarm at midnight, twelve-hour display, idle rates swapped.
        send_idle_pct <= 51;
        recv_idle_pct <= 29;
        write_register(CFG_ALARM_HOURS, 6'd0);
        write_register(CFG_ALARM_MINUTES, 6'd0);
        write_register(CFG_ALARM_SECONDS, 6'd0);
        write_register(CFG_TWELVE_HOUR_MODE, 6'd1);
        queue_random(550);
        wait_until_drained();

        // Alarm registers beyond any reachable time, so the alarm can never
        // match; writes to unused indexes must change nothing. No idling.
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_register(CFG_ALARM_HOURS, 6'h3F);
        write_register(CFG_ALARM_MINUTES, 6'h3F);
        write_register(CFG_ALARM_SECONDS, 6'h3F);
        write_register(CFG_TWELVE_HOUR_MODE, 6'd0);
        write_register(CFG_SPARE_LOW, 6'h3F);
        write_register(CFG_SPARE_HIGH, 6'h2A);
        queue_random(250);
        wait_until_drained();

        // A random alarm time with the alarm disarmed again.
        write_register(CFG_ALARM_HOURS, 6'($urandom_range(23)));
        write_register(CFG_ALARM_MINUTES, 6'($urandom_range(59)));
        write_register(CFG_ALARM_SECONDS, 6'($urandom_range(59)));
        write_register(CFG_ALARM_ENABLE, 6'd0);
        write_register(CFG_TWELVE_HOUR_MODE, 6'd1);
        queue_random(250);
        wait_until_drained();

        if (expected_readings.size() != 0)
        begin
            $display("%0t: %0d predicted results never arrived", $time,
                     expected_readings.size());
            failures++;
        end
        if (failures == 0)
            $display("rtc_calendar_alarm_test: PASS");
        else
            $display("rtc_calendar_alarm_test: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("rtc_calendar_alarm_test: FAIL");
        $finish;
    end

endmodule
